/* rtl/gsa_pkg.sv */
// Shared constants, codes and types of the generational slot allocator.
// No dependencies; every module of the block imports this package.
`default_nettype none

package gsa_pkg;

  localparam int unsigned SlotCount  = 64;
  localparam int unsigned SlotW      = $clog2(SlotCount);
  localparam int unsigned CountW     = $clog2(SlotCount + 1);
  localparam int unsigned ByteBudget = 16777216;
  localparam int unsigned BytesW     = 25;
  localparam int unsigned SizeW      = 20;
  localparam int unsigned GenW       = 32;
  localparam int unsigned DevW       = 32;
  localparam int unsigned HSlotW     = 8;

  localparam logic [BytesW-1:0] Budget      = BytesW'(ByteBudget);
  localparam logic [BytesW-1:0] MinArtifact = BytesW'(27);
  localparam logic [BytesW-1:0] MaxArtifact = BytesW'(512 * 1024);

  localparam logic [7:0] HdrByte0 = 8'h46;
  localparam logic [7:0] HdrByte1 = 8'h53;
  localparam logic [7:0] HdrByte2 = 8'h48;
  localparam logic [7:0] HdrByte3 = 8'd12;

  localparam logic [GenW-1:0] GenExhausted = '1;

  localparam logic [7:0] CfgDeviceId   = 8'd0;
  localparam logic [7:0] CfgDeviceLost = 8'd1;

  typedef enum logic [1:0] {
    KindAlloc   = 2'd0,
    KindRelease = 2'd1,
    KindCheck   = 2'd2,
    KindNone    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusLost        = 2'd1,
    StatusBadArtifact = 2'd2,
    StatusBudget      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  typedef struct packed {
    logic             take;
    logic             drop;
    logic             refree;
    logic [SlotW-1:0] slot;
  } flag_upd_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
  } pick_t;

endpackage

`default_nettype wire

/* rtl/gsa_slot_mem.sv */
// Slot table storage: byte size and generation per slot, registered read.
// Depends on gsa_pkg.
`default_nettype none

module gsa_slot_mem (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [gsa_pkg::SlotW-1:0]  rd_addr_i,
  output logic [gsa_pkg::SizeW-1:0]  rd_size_o,
  output logic [gsa_pkg::GenW-1:0]   rd_gen_o,
  input  logic [gsa_pkg::SlotW-1:0]  wr_addr_i,
  input  logic                       size_we_i,
  input  logic [gsa_pkg::SizeW-1:0]  size_wdata_i,
  input  logic                       gen_we_i,
  input  logic [gsa_pkg::GenW-1:0]   gen_wdata_i
);
  import gsa_pkg::*;

  logic [SizeW-1:0] size_mem [SlotCount];
  logic [GenW-1:0]  gen_mem  [SlotCount];
  logic [SizeW-1:0] rd_size_q;
  logic [GenW-1:0]  rd_gen_q;

  always_ff @(posedge clk_i) begin
    if (size_we_i) begin
      size_mem[wr_addr_i] <= size_wdata_i;
    end
    if (gen_we_i) begin
      gen_mem[wr_addr_i] <= gen_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_size_q <= size_mem[rd_addr_i];
      rd_gen_q  <= gen_mem[rd_addr_i];
    end
  end

  assign rd_size_o = rd_size_q;
  assign rd_gen_o  = rd_gen_q;

endmodule

`default_nettype wire

/* rtl/gsa_flags.sv */
// Per-slot live and reusable flags with a lowest-free-slot priority encoder.
// Depends on gsa_pkg.
`default_nettype none

module gsa_flags (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gsa_pkg::flag_upd_t            upd_i,
  output gsa_pkg::pick_t                pick_o,
  output logic [gsa_pkg::SlotCount-1:0] live_o
);
  import gsa_pkg::*;

  logic [SlotCount-1:0] live_q, live_d;
  logic [SlotCount-1:0] free_q, free_d;
  pick_t                pick;

  always_comb begin
    live_d = live_q;
    free_d = free_q;
    if (upd_i.take) begin
      live_d[upd_i.slot] = 1'b1;
      free_d[upd_i.slot] = 1'b0;
    end else if (upd_i.drop) begin
      live_d[upd_i.slot] = 1'b0;
      free_d[upd_i.slot] = upd_i.refree;
    end
  end

  always_comb begin
    pick = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        pick.found = 1'b1;
        pick.slot  = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      free_q <= '0;
    end else begin
      live_q <= live_d;
      free_q <= free_d;
    end
  end

  assign pick_o = pick;
  assign live_o = live_q;

endmodule

`default_nettype wire

/* rtl/generational_slot_allocator.sv */
// Top level of the generational slot allocator: control, counters, output register.
// Depends on gsa_pkg, gsa_slot_mem and gsa_flags.
//
//   channel   dir  handshake               payload
//   in        in   in_valid_i/in_ready_o   kind, artifact, header bytes, handle
//   out       out  out_valid_o/out_ready_i status, owned, handle, totals
//   cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item gets the slot table read on acceptance, then the
// read-modify-write of the table and the counters in the execute state.
// Reset clears flags and counters; the table needs no clearing pass.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and holds in the execute state until that result is transferred.
`default_nettype none

module generational_slot_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [gsa_pkg::BytesW-1:0]   artifact_length_i,
  input  logic [7:0]                   header_byte0_i,
  input  logic [7:0]                   header_byte1_i,
  input  logic [7:0]                   header_byte2_i,
  input  logic [7:0]                   header_byte3_i,
  input  logic [gsa_pkg::DevW-1:0]     handle_device_i,
  input  logic [gsa_pkg::HSlotW-1:0]   handle_slot_i,
  input  logic [gsa_pkg::GenW-1:0]     handle_generation_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         owned_o,
  output logic [gsa_pkg::DevW-1:0]     out_device_o,
  output logic [gsa_pkg::SlotW-1:0]    out_slot_o,
  output logic [gsa_pkg::GenW-1:0]     out_generation_o,
  output logic [gsa_pkg::BytesW-1:0]   total_bytes_o,
  output logic [gsa_pkg::CountW-1:0]   live_count_o
);
  import gsa_pkg::*;

  state_e state_q, state_d;

  logic [DevW-1:0]   device_id_q;
  logic              device_lost_q;
  logic [CountW-1:0] slots_q, slots_d;
  logic [CountW-1:0] live_cnt_q, live_cnt_d;
  logic [BytesW-1:0] bytes_q, bytes_d;

  kind_e             kind_q;
  logic [BytesW-1:0] len_q;
  logic              hdr_ok_q;
  logic [DevW-1:0]   hdev_q;
  logic              hslot_ok_q;
  logic [GenW-1:0]   hgen_q;
  logic [SlotW-1:0]  addr_q;
  logic              found_q;
  logic              grow_ok_q;

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              owned_q;
  logic [DevW-1:0]   odev_q;
  logic [SlotW-1:0]  oslot_q;
  logic [GenW-1:0]   ogen_q;
  logic [BytesW-1:0] obytes_q;
  logic [CountW-1:0] ocnt_q;

  logic              in_fire;
  logic              exec_fire;
  logic [SlotW-1:0]  rd_addr;
  kind_e             in_kind;
  pick_t             pick;
  logic [SlotCount-1:0] live_vec;
  flag_upd_t         upd;
  logic [SizeW-1:0]  rd_size;
  logic [GenW-1:0]   rd_gen;
  logic [GenW-1:0]   gen_inc;
  logic              is_alloc, is_handle;
  logic              bad_art, over_budget, table_full;
  logic              alloc_do, owned, rel_do;
  logic              size_we, gen_we;
  logic [SizeW-1:0]  size_wdata;
  logic [GenW-1:0]   gen_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == StExec) && (!out_valid_q || out_ready_i);
  assign in_kind     = kind_e'(kind_i);

  assign rd_addr = (in_kind != KindAlloc) ? handle_slot_i[SlotW-1:0] :
                   pick.found             ? pick.slot : slots_q[SlotW-1:0];

  gsa_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .pick_o (pick),
    .live_o (live_vec)
  );

  gsa_slot_mem u_mem (
    .clk_i        (clk_i),
    .rd_en_i      (in_fire),
    .rd_addr_i    (rd_addr),
    .rd_size_o    (rd_size),
    .rd_gen_o     (rd_gen),
    .wr_addr_i    (addr_q),
    .size_we_i    (size_we),
    .size_wdata_i (size_wdata),
    .gen_we_i     (gen_we),
    .gen_wdata_i  (gen_wdata)
  );

  always_comb begin
    gen_inc     = rd_gen + GenW'(1);
    is_alloc    = (kind_q == KindAlloc);
    is_handle   = (kind_q == KindRelease) || (kind_q == KindCheck);
    bad_art     = !hdr_ok_q || (len_q < MinArtifact) || (len_q > MaxArtifact);
    over_budget = len_q > (Budget - bytes_q);
    table_full  = !found_q && !grow_ok_q;
    status_d    = StatusOk;
    if (is_alloc) begin
      priority if (device_lost_q) begin
        status_d = StatusLost;
      end else if (bad_art) begin
        status_d = StatusBadArtifact;
      end else if (over_budget || table_full) begin
        status_d = StatusBudget;
      end else begin
        status_d = StatusOk;
      end
    end
    alloc_do = exec_fire && is_alloc && (status_d == StatusOk);
    owned    = is_handle && (hdev_q == device_id_q) && hslot_ok_q &&
               live_vec[addr_q] && (rd_gen == hgen_q);
    rel_do   = exec_fire && owned && (kind_q == KindRelease);

    size_we    = alloc_do || rel_do;
    size_wdata = alloc_do ? len_q[SizeW-1:0] : '0;
    gen_we     = (alloc_do && !found_q) || rel_do;
    gen_wdata  = rel_do ? gen_inc : '0;

    upd.take   = alloc_do;
    upd.drop   = rel_do;
    upd.refree = gen_inc != GenExhausted;
    upd.slot   = addr_q;

    bytes_d    = bytes_q;
    live_cnt_d = live_cnt_q;
    slots_d    = slots_q;
    if (alloc_do) begin
      bytes_d    = bytes_q + len_q;
      live_cnt_d = live_cnt_q + CountW'(1);
      if (!found_q) begin
        slots_d = slots_q + CountW'(1);
      end
    end else if (rel_do) begin
      bytes_d    = bytes_q - BytesW'(rd_size);
      live_cnt_d = live_cnt_q - CountW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_fire) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      device_id_q   <= '0;
      device_lost_q <= 1'b0;
      slots_q       <= '0;
      live_cnt_q    <= '0;
      bytes_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      slots_q     <= slots_d;
      live_cnt_q  <= live_cnt_d;
      bytes_q     <= bytes_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgDeviceId) begin
          device_id_q <= cfg_data_i;
        end else if (cfg_index_i == CfgDeviceLost) begin
          device_lost_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= in_kind;
      len_q      <= artifact_length_i;
      hdr_ok_q   <= (header_byte0_i == HdrByte0) && (header_byte1_i == HdrByte1) &&
                    (header_byte2_i == HdrByte2) && (header_byte3_i == HdrByte3);
      hdev_q     <= handle_device_i;
      hslot_ok_q <= {1'b0, handle_slot_i} < (HSlotW + 1)'(SlotCount);
      hgen_q     <= handle_generation_i;
      addr_q     <= rd_addr;
      found_q    <= pick.found;
      grow_ok_q  <= slots_q != CountW'(SlotCount);
    end
    if (exec_fire) begin
      status_q <= status_d;
      owned_q  <= owned;
      odev_q   <= alloc_do ? device_id_q : '0;
      oslot_q  <= alloc_do ? addr_q : '0;
      ogen_q   <= (alloc_do && found_q) ? rd_gen : '0;
      obytes_q <= bytes_d;
      ocnt_q   <= live_cnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign owned_o          = owned_q;
  assign out_device_o     = odev_q;
  assign out_slot_o       = oslot_q;
  assign out_generation_o = ogen_q;
  assign total_bytes_o    = obytes_q;
  assign live_count_o     = ocnt_q;

  a_live_le_grown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= slots_q)
    else $error("live count above grown slot count");

  a_bytes_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= Budget)
    else $error("bytes held above budget");

  a_exec_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && !out_valid_q) |=> (out_valid_q && state_q == StIdle))
    else $error("result not registered after table update");

  a_live_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_vec) == int'(live_cnt_q))
    else $error("live counter differs from live flags");

endmodule

`default_nettype wire
